/* hw/rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg - shared types and constants
// Request/result structs, mode and status codes, exp tables, saturation.
// ----------------------------------------------------------------------------
package sam_pkg;

	localparam int MAX_POSITIONS = 64;
	localparam int NUM_MAPS      = 2;
	localparam int POS_W         = $clog2(MAX_POSITIONS);
	localparam int MAP_W         = 1;
	localparam int TBL_AW        = MAP_W + 2 * POS_W;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [4:0] FIXED_CLASS = 5'd21;
	localparam logic [15:0] HALF_Q16   = 16'd32768;

	// mode codes
	localparam logic [1:0] MODE_LOAD_TABLE = 2'd0;
	localparam logic [1:0] MODE_LOAD_POS   = 2'd1;
	localparam logic [1:0] MODE_RECOMPUTE  = 2'd2;
	localparam logic [1:0] MODE_SWAP       = 2'd3;

	// status codes
	localparam logic [2:0] ST_LOAD_DONE = 3'd0;
	localparam logic [2:0] ST_DROP      = 3'd1;
	localparam logic [2:0] ST_RISE      = 3'd2;
	localparam logic [2:0] ST_REJECT    = 3'd3;
	localparam logic [2:0] ST_INVALID   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_USED_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TEMP    = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic               map_select;
		logic [5:0]         row_peak;
		logic [5:0]         col_peak;
		logic signed [23:0] energy_value;
		logic [5:0]         load_position;
		logic [5:0]         load_peak;
		logic [4:0]         residue_class;
		logic [5:0]         swap_low;
		logic [5:0]         swap_high;
		logic [15:0]        random_u;
	} sam_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [47:0] total_energy;
		logic signed [31:0] map0_energy;
		logic signed [31:0] map1_energy;
		logic signed [47:0] delta_energy;
	} sam_res_t;

	// round(65536*exp(-n)) and round(65536*exp(-j/16))
	localparam logic [16:0] EXPI [16] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
		17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
	};
	localparam logic [16:0] EXPF [16] = '{
		17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
		17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
		17'd27319, 17'd25664
	};

	function automatic logic signed [31:0] sat_to32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -35'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat_to48(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v > 50'sh0_7FFF_FFFF_FFFF)
			r = 48'sh7FFF_FFFF_FFFF;
		else if (v < -50'sh0_8000_0000_0000)
			r = 48'sh8000_0000_0000;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

/* hw/rtl/sam_ram.sv */
// ----------------------------------------------------------------------------
// sam_ram - simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sam_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/swap_move_annealing_step.sv */
// ----------------------------------------------------------------------------
// swap_move_annealing_step - Metropolis swap move over a peak chain
// Sequenced datapath with one shared multiplier and per-map accumulators.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carries one request (sam_req_t); out_valid/out_ready
//    returns exactly one result (sam_res_t) per request.
//  - cfg_we/cfg_index/cfg_wdata writes a register; only write
//    while no request is in flight.
//  - Each link pair reads two table entries per map in a recompute and
//    four in a swap, all through the single table read port; a swap
//    touches at most four pairs, a recompute all used_length-1 of them.
//  - One request at a time; in_ready is high only while the sequencer is
//    idle. A finished result sits in the output register, so the next
//    request may be taken and worked while out_ready is low; the sequencer
//    only waits at its end for the output register to free up.
//  - Reset clears the held energies and the registers to their defaults.
//    The table, peak order and class stores hold garbage until loaded.
// ----------------------------------------------------------------------------
module swap_move_annealing_step
	import sam_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sam_req_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sam_res_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [25:0] {
		S_IDLE   = 26'd1 << 0,
		S_DISP   = 26'd1 << 1,
		S_CLS0   = 26'd1 << 2,
		S_CLS1   = 26'd1 << 3,
		S_CHK    = 26'd1 << 4,
		S_CAND   = 26'd1 << 5,
		S_PK0    = 26'd1 << 6,
		S_PK1    = 26'd1 << 7,
		S_PK2    = 26'd1 << 8,
		S_TBL    = 26'd1 << 9,
		S_DRAIN  = 26'd1 << 10,
		S_MAPSAT = 26'd1 << 11,
		S_MW0    = 26'd1 << 12,
		S_MW1    = 26'd1 << 13,
		S_MW2    = 26'd1 << 14,
		S_TOT    = 26'd1 << 15,
		S_DLT    = 26'd1 << 16,
		S_DEC    = 26'd1 << 17,
		S_META   = 26'd1 << 18,
		S_METB   = 26'd1 << 19,
		S_METC   = 26'd1 << 20,
		S_METD   = 26'd1 << 21,
		S_COM0   = 26'd1 << 22,
		S_COM1   = 26'd1 << 23,
		S_DONE   = 26'd1 << 24,
		S_SPARE  = 26'd1 << 25
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]  used_length_q;
	logic [1:0]  map_count_q;
	logic [15:0] weight0_q, weight1_q;
	logic [31:0] inv_temp_q;
	logic [6:0]  len_eff;
	logic [1:0]  mc_eff;

	// held state
	logic signed [31:0] held_map_q [NUM_MAPS];
	logic signed [47:0] held_tot_q;

	// working registers
	sam_req_t           req_q;
	logic [POS_W-1:0]   lo_q, hi_q, plo_q, phi_q, pa_q, pb_q, pair_q;
	logic [4:0]         cls_lo_q;
	logic [1:0]         cand_q;
	logic               slot_m_q;
	logic [1:0]         slot_j_q;
	logic               tag_vld_q, tag_m_q, tag_sub_q;
	logic signed [33:0] acc_q [NUM_MAPS];
	logic signed [31:0] nmap_q [NUM_MAPS];
	logic signed [49:0] tot_acc_q;
	logic signed [47:0] ntot_q, delta_q;
	logic [79:0]        full_q;
	logic [2:0]         status_q;
	logic signed [57:0] mult_q;
	logic               out_valid_q;
	sam_res_t           out_q;

	// memory ports
	logic               tbl_we, pos_we, cls_we;
	logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
	logic [23:0]        tbl_rdata;
	logic [POS_W-1:0]   pos_waddr, pos_wdata, pos_raddr, pos_rdata;
	logic [4:0]         cls_rdata;

	// shared multiplier operands
	logic signed [24:0] mul_a;
	logic signed [32:0] mul_b;

	logic               is_swap;
	logic [POS_W-1:0]   pair_nxt, na, nb;
	logic [6:0]         cand_c;
	logic               cand_ok;
	logic               slot_last_j, slot_last;
	logic [7:0]         q_idx;
	logic [16:0]        p_val;

	assign len_eff = (used_length_q > 7'(MAX_POSITIONS)) ? 7'(MAX_POSITIONS) : used_length_q;
	assign mc_eff  = (map_count_q > 2'(NUM_MAPS)) ? 2'(NUM_MAPS) : map_count_q;
	assign is_swap = (req_q.mode == MODE_SWAP);
	assign pair_nxt = pair_q + POS_W'(1);

	// peaks of the current pair after the proposed swap
	assign na = (pair_q == lo_q) ? phi_q : ((pair_q == hi_q) ? plo_q : pa_q);
	assign nb = (pair_nxt == lo_q) ? phi_q : ((pair_nxt == hi_q) ? plo_q : pb_q);

	// affected pair candidates: lo-1, lo, hi-1, hi
	always_comb begin
		cand_c  = '0;
		cand_ok = 1'b1;
		unique case (cand_q)
			2'd0: begin
				cand_c  = {1'b0, lo_q} - 7'd1;
				cand_ok = (lo_q != '0);
			end
			2'd1: cand_c = {1'b0, lo_q};
			2'd2: begin
				cand_c  = {1'b0, hi_q} - 7'd1;
				cand_ok = (hi_q - POS_W'(1) != lo_q);
			end
			default: cand_c = {1'b0, hi_q};
		endcase
		if (cand_c + 7'd1 >= len_eff)
			cand_ok = 1'b0;
	end

	assign slot_last_j = is_swap ? (slot_j_q == 2'd3) : (slot_j_q == 2'd1);
	assign slot_last   = slot_last_j && !(slot_m_q == 1'b0 && mc_eff == 2'd2);

	assign q_idx = full_q[55:48];
	assign p_val = mult_q[32:16];

	// memory address and write control
	always_comb begin
		tbl_we    = (state_q == S_DISP) && (req_q.mode == MODE_LOAD_TABLE);
		tbl_waddr = {req_q.map_select, req_q.row_peak, req_q.col_peak};
		unique case (slot_j_q)
			2'd0:    tbl_raddr = {slot_m_q, pb_q, pa_q};
			2'd1:    tbl_raddr = {slot_m_q, pa_q, pb_q};
			2'd2:    tbl_raddr = {slot_m_q, nb, na};
			default: tbl_raddr = {slot_m_q, na, nb};
		endcase

		cls_we    = (state_q == S_DISP) && (req_q.mode == MODE_LOAD_POS);
		pos_we    = cls_we || (state_q == S_COM0) || (state_q == S_COM1);
		pos_waddr = req_q.load_position;
		pos_wdata = req_q.load_peak;
		if (state_q == S_COM0) begin
			pos_waddr = lo_q;
			pos_wdata = phi_q;
		end else if (state_q == S_COM1) begin
			pos_waddr = hi_q;
			pos_wdata = plo_q;
		end

		priority case (1'b1)
			state_q == S_CLS0: pos_raddr = lo_q;
			state_q == S_CLS1: pos_raddr = hi_q;
			state_q == S_PK1:  pos_raddr = pair_nxt;
			default:           pos_raddr = pair_q;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MW0: begin
				mul_a = {9'd0, weight0_q};
				mul_b = {held_map_q[0][31] & 1'b0 | nmap_q[0][31], nmap_q[0]};
			end
			S_MW1: begin
				mul_a = {9'd0, weight1_q};
				mul_b = {nmap_q[1][31], nmap_q[1]};
			end
			S_DEC: begin
				mul_a = {1'b0, delta_q[23:0]};
				mul_b = {1'b0, inv_temp_q};
			end
			S_META: begin
				mul_a = {1'b0, delta_q[47:24]};
				mul_b = {1'b0, inv_temp_q};
			end
			S_METC: begin
				mul_a = {8'd0, EXPI[q_idx[7:4]]};
				mul_b = {16'd0, EXPF[q_idx[3:0]]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mult_q <= mul_a * mul_b;
	end

	sam_ram #(.ADDR_W(TBL_AW), .DATA_W(24)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (req_q.energy_value),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	sam_ram #(.ADDR_W(POS_W), .DATA_W(POS_W)) u_peak (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	sam_ram #(.ADDR_W(POS_W), .DATA_W(5)) u_cls (
		.clk   (clk),
		.we    (cls_we),
		.waddr (req_q.load_position),
		.wdata (req_q.residue_class),
		.raddr (pos_raddr),
		.rdata (cls_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_length_q <= 7'd64;
			map_count_q   <= 2'd2;
			weight0_q     <= 16'd4096;
			weight1_q     <= 16'd4096;
			inv_temp_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USED_LENGTH: used_length_q <= cfg_wdata[6:0];
				REG_MAP_COUNT:   map_count_q   <= cfg_wdata[1:0];
				REG_WEIGHT0:     weight0_q     <= cfg_wdata[15:0];
				REG_WEIGHT1:     weight1_q     <= cfg_wdata[15:0];
				REG_INV_TEMP:    inv_temp_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			held_map_q[0] <= '0;
			held_map_q[1] <= '0;
			held_tot_q    <= '0;
			tag_vld_q     <= 1'b0;
		end else begin
			tag_vld_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DISP;
				end
				S_DISP: begin
					unique case (req_q.mode)
						MODE_LOAD_TABLE, MODE_LOAD_POS: state_q <= S_DONE;
						MODE_RECOMPUTE: begin
							if (len_eff >= 7'd2 && mc_eff != 2'd0)
								state_q <= S_PK0;
							else
								state_q <= S_MAPSAT;
						end
						default: state_q <= S_CLS0;
					endcase
				end
				S_CLS0: state_q <= S_CLS1;
				S_CLS1: state_q <= S_CHK;
				S_CHK: begin
					if ({1'b0, hi_q} >= len_eff || lo_q == hi_q || cls_lo_q != cls_rdata ||
					    cls_lo_q == FIXED_CLASS)
						state_q <= S_DONE;
					else if (mc_eff == 2'd0)
						state_q <= S_MAPSAT;
					else
						state_q <= S_CAND;
				end
				S_CAND: begin
					if (cand_ok)
						state_q <= S_PK0;
					else if (cand_q == 2'd3)
						state_q <= S_MAPSAT;
				end
				S_PK0: state_q <= S_PK1;
				S_PK1: state_q <= S_PK2;
				S_PK2: state_q <= S_TBL;
				S_TBL: begin
					tag_vld_q <= 1'b1;
					if (slot_last)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (is_swap)
						state_q <= (cand_q == 2'd3) ? S_MAPSAT : S_CAND;
					else if ({2'b0, pair_q} + 8'd2 < {1'b0, len_eff})
						state_q <= S_PK0;
					else
						state_q <= S_MAPSAT;
				end
				S_MAPSAT: state_q <= S_MW0;
				S_MW0:    state_q <= S_MW1;
				S_MW1:    state_q <= S_MW2;
				S_MW2:    state_q <= S_TOT;
				S_TOT: begin
					if (is_swap) begin
						state_q <= S_DLT;
					end else begin
						held_map_q[0] <= nmap_q[0];
						held_map_q[1] <= nmap_q[1];
						held_tot_q    <= sat_to48(tot_acc_q);
						state_q       <= S_DONE;
					end
				end
				S_DLT: state_q <= S_DEC;
				S_DEC: begin
					if (delta_q < 0 || (delta_q == 0 && req_q.random_u > HALF_Q16))
						state_q <= S_COM0;
					else if (delta_q == 0)
						state_q <= S_DONE;
					else
						state_q <= S_META;
				end
				S_META: state_q <= S_METB;
				S_METB: state_q <= S_METC;
				S_METC: state_q <= (|full_q[79:56]) ? S_DONE : S_METD;
				S_METD: state_q <= (p_val > {1'b0, req_q.random_u}) ? S_COM0 : S_DONE;
				S_COM0: begin
					held_map_q[0] <= nmap_q[0];
					held_map_q[1] <= nmap_q[1];
					held_tot_q    <= ntot_q;
					state_q       <= S_COM1;
				end
				S_COM1: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		tag_m_q   <= slot_m_q;
		tag_sub_q <= is_swap && !slot_j_q[1];

		if (tag_vld_q) begin
			if (tag_sub_q)
				acc_q[tag_m_q] <= acc_q[tag_m_q] - 34'(signed'(tbl_rdata));
			else
				acc_q[tag_m_q] <= acc_q[tag_m_q] + 34'(signed'(tbl_rdata));
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					req_q <= in_data;
			end
			S_DISP: begin
				status_q <= ST_LOAD_DONE;
				delta_q  <= '0;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				pair_q   <= '0;
				lo_q <= (req_q.swap_low < req_q.swap_high) ? req_q.swap_low : req_q.swap_high;
				hi_q <= (req_q.swap_low < req_q.swap_high) ? req_q.swap_high : req_q.swap_low;
			end
			S_CLS1: begin
				cls_lo_q <= cls_rdata;
				plo_q    <= pos_rdata;
			end
			S_CHK: begin
				phi_q    <= pos_rdata;
				cand_q   <= '0;
				status_q <= ST_INVALID;
			end
			S_CAND: begin
				if (cand_ok)
					pair_q <= cand_c[POS_W-1:0];
				else if (cand_q != 2'd3)
					cand_q <= cand_q + 2'd1;
			end
			S_PK1: pa_q <= pos_rdata;
			S_PK2: begin
				pb_q     <= pos_rdata;
				slot_m_q <= 1'b0;
				slot_j_q <= '0;
			end
			S_TBL: begin
				if (!slot_last_j) begin
					slot_j_q <= slot_j_q + 2'd1;
				end else begin
					slot_j_q <= '0;
					slot_m_q <= 1'b1;
				end
			end
			S_DRAIN: begin
				if (is_swap)
					cand_q <= cand_q + 2'd1;
				else
					pair_q <= pair_nxt;
			end
			S_MAPSAT: begin
				nmap_q[0] <= sat_to32(35'(is_swap ? held_map_q[0] : 32'sd0) + 35'(acc_q[0]));
				nmap_q[1] <= sat_to32(35'(is_swap ? held_map_q[1] : 32'sd0) + 35'(acc_q[1]));
				tot_acc_q <= '0;
			end
			S_MW1: if (mc_eff >= 2'd1) tot_acc_q <= tot_acc_q + mult_q[49:0];
			S_MW2: if (mc_eff >= 2'd2) tot_acc_q <= tot_acc_q + mult_q[49:0];
			S_TOT: ntot_q <= sat_to48(tot_acc_q);
			S_DLT: delta_q <= sat_to48(50'(ntot_q) - 50'(held_tot_q));
			S_DEC: begin
				if (delta_q < 0)
					status_q <= ST_DROP;
				else if (delta_q == 0)
					status_q <= (req_q.random_u > HALF_Q16) ? ST_RISE : ST_REJECT;
			end
			S_META: full_q <= {22'd0, mult_q};
			S_METB: full_q <= full_q + {mult_q[55:0], 24'd0};
			S_METC: if (|full_q[79:56]) status_q <= ST_REJECT;
			S_METD: status_q <= (p_val > {1'b0, req_q.random_u}) ? ST_RISE : ST_REJECT;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.status       <= status_q;
					out_q.total_energy <= held_tot_q;
					out_q.map0_energy  <= held_map_q[0];
					out_q.map1_energy  <= held_map_q[1];
					out_q.delta_energy <= (status_q == ST_INVALID) ? 48'sd0 : delta_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_invalid_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_INVALID |-> out_q.delta_energy == 48'sd0)
		else $error("invalid swap carries a nonzero delta");

	a_drop_negative: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_DROP |-> out_q.delta_energy[47])
		else $error("accepted drop without a negative delta");

	a_rise_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_RISE || out_q.status == ST_REJECT)
		|-> !out_q.delta_energy[47])
		else $error("tie/rise or reject with a negative delta");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
		else $error("finished request did not reach the output register");

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		tag_vld_q |-> !pos_we && !tbl_we)
		else $error("store written while table reads are in flight");

endmodule

/* tb/sv/tb_swap_move_annealing_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swap_move_annealing_step - self-checking bench for the swap-move step
// Drives table, position, recompute and swap requests under random flow
// control, predicts every result in-bench, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_swap_move_annealing_step;
	import sam_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_PEAKS     = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	sam_req_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	sam_res_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	swap_move_annealing_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Peaks placed on the chain always come from this set, and every table
	// entry between two of them is loaded up front, so no unloaded entry is
	// ever read. 0 and 63 toggle every peak bit.
	const logic [5:0] peak_set [N_PEAKS] = '{6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd63};

	// ---- mirrored block state ------------------------------------------------
	logic signed [23:0] pair_e [2][64][64];
	logic [5:0]         chain_peak [64];
	logic [4:0]         chain_class [64];
	longint             held_map [2];
	longint             held_total;
	int                 cfg_len;
	int                 cfg_maps;
	longint             cfg_w [2];
	logic [31:0]        cfg_invt;

	sam_res_t results_pending [$];

	// ---- bookkeeping -----------------------------------------------------------
	int     mismatches;
	int     orphans;
	int     n_checked;
	int     n_sent;
	int     status_seen [5];
	longint cycle_count;

	// sender burst state, receiver stall state
	int burst_left;
	int hold_left;
	int rx_mode;
	int rx_phase_left;

	// ---- clock ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---- predictor -----------------------------------------------------------
	function automatic longint sat_n(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// both directed entries of the link between chain slots i and i+1
	function automatic longint link_e(input int m, input logic [5:0] ord [64], input int i);
		logic [5:0] a;
		logic [5:0] b;
		a = ord[i];
		b = ord[i + 1];
		return longint'(pair_e[m][b][a]) + longint'(pair_e[m][a][b]);
	endfunction

	function automatic longint weighted_sum(input longint mp [2]);
		longint t;
		t = 0;
		for (int m = 0; m < cfg_maps; m++)
			t += cfg_w[m] * mp[m];
		return sat_n(t, 48);
	endfunction

	// uphill move: q = delta*W in 1/16 units, exp from the two lookup tables
	function automatic bit rise_accepts(input longint dlt, input logic [15:0] u);
		bit [63:0] d;
		bit [63:0] whi;
		bit [63:0] wlo;
		bit [63:0] q;
		bit [63:0] ei;
		bit [63:0] ef;
		bit [63:0] p;
		d   = dlt;
		whi = cfg_invt[31:16];
		wlo = cfg_invt[15:0];
		q   = (d * whi + ((d * wlo) >> 16)) >> 32;
		if (q >= 256)
			return 1'b0;
		ei = EXPI[q[7:4]];
		ef = EXPF[q[3:0]];
		p  = (ei * ef) >> 16;
		return p > u;
	endfunction

	function automatic sam_res_t anneal_predict(input sam_req_t r);
		sam_res_t   res;
		logic [5:0] nord [64];
		longint     nmap [2];
		longint     ntot;
		longint     dlt;
		longint     s;
		int         lo;
		int         hi;
		int         n;
		int         cand [4];
		int         links [4];
		bit         dup;
		bit         accept;
		logic [5:0] t;
		res = '0;
		dlt = 0;
		res.status = ST_LOAD_DONE;
		case (r.mode)
			MODE_LOAD_TABLE: pair_e[r.map_select][r.row_peak][r.col_peak] = r.energy_value;
			MODE_LOAD_POS: begin
				chain_peak[r.load_position]  = r.load_peak;
				chain_class[r.load_position] = r.residue_class;
			end
			MODE_RECOMPUTE: begin
				for (int m = 0; m < 2; m++) begin
					s = 0;
					if (m < cfg_maps)
						for (int i = 0; i + 1 < cfg_len; i++)
							s += link_e(m, chain_peak, i);
					held_map[m] = sat_n(s, 32);
				end
				held_total = weighted_sum(held_map);
			end
			default: begin
				lo = (r.swap_low < r.swap_high) ? r.swap_low : r.swap_high;
				hi = (r.swap_low < r.swap_high) ? r.swap_high : r.swap_low;
				if (hi >= cfg_len || lo == hi || chain_class[lo] != chain_class[hi] ||
						chain_class[lo] == FIXED_CLASS) begin
					res.status = ST_INVALID;
				end else begin
					nord = chain_peak;
					t = nord[lo];
					nord[lo] = nord[hi];
					nord[hi] = t;
					// links touched by the swap, each once
					cand = '{lo - 1, lo, hi - 1, hi};
					n = 0;
					for (int k = 0; k < 4; k++) begin
						dup = 1'b0;
						if (cand[k] >= 0 && cand[k] + 1 < cfg_len) begin
							for (int j = 0; j < n; j++)
								if (links[j] == cand[k])
									dup = 1'b1;
							if (!dup) begin
								links[n] = cand[k];
								n++;
							end
						end
					end
					for (int m = 0; m < 2; m++) begin
						s = 0;
						if (m < cfg_maps)
							for (int k = 0; k < n; k++)
								s += link_e(m, nord, links[k]) - link_e(m, chain_peak, links[k]);
						nmap[m] = sat_n(held_map[m] + s, 32);
					end
					ntot = weighted_sum(nmap);
					dlt  = sat_n(ntot - held_total, 48);
					if (dlt < 0) begin
						accept = 1'b1;
						res.status = ST_DROP;
					end else begin
						accept = (dlt == 0) ? (r.random_u > HALF_Q16) : rise_accepts(dlt, r.random_u);
						res.status = accept ? ST_RISE : ST_REJECT;
					end
					if (accept) begin
						chain_peak = nord;
						held_map   = nmap;
						held_total = ntot;
					end
				end
			end
		endcase
		res.total_energy = held_total[47:0];
		res.map0_energy  = held_map[0][31:0];
		res.map1_energy  = held_map[1][31:0];
		res.delta_energy = dlt[47:0];
		return res;
	endfunction

	// ---- request builders ------------------------------------------------------
	// every field but the mode gets random content first; the mode then decides what matters
	function automatic sam_req_t noise_req();
		sam_req_t r;
		r.mode          = MODE_RECOMPUTE;
		r.map_select    = $urandom_range(0, 1);
		r.row_peak      = $urandom_range(0, 63);
		r.col_peak      = $urandom_range(0, 63);
		r.energy_value  = $urandom;
		r.load_position = $urandom_range(0, 63);
		r.load_peak     = $urandom_range(0, 63);
		r.residue_class = $urandom_range(0, 21);
		r.swap_low      = $urandom_range(0, 63);
		r.swap_high     = $urandom_range(0, 63);
		r.random_u      = $urandom_range(0, 65535);
		return r;
	endfunction

	function automatic sam_req_t mk_table(input bit ms, input logic [5:0] row, col,
			input logic signed [23:0] v);
		sam_req_t r;
		r = noise_req();
		r.mode = MODE_LOAD_TABLE;
		r.map_select = ms;
		r.row_peak = row;
		r.col_peak = col;
		r.energy_value = v;
		return r;
	endfunction

	function automatic sam_req_t mk_pos(input logic [5:0] pos, pk, input logic [4:0] cls);
		sam_req_t r;
		r = noise_req();
		r.mode = MODE_LOAD_POS;
		r.load_position = pos;
		r.load_peak = pk;
		r.residue_class = cls;
		return r;
	endfunction

	function automatic sam_req_t mk_swap(input logic [5:0] a, b, input logic [15:0] u);
		sam_req_t r;
		r = noise_req();
		r.mode = MODE_SWAP;
		r.swap_low = a;
		r.swap_high = b;
		r.random_u = u;
		return r;
	endfunction

	// mostly small energies so that uphill moves land near the exp knee
	function automatic logic signed [23:0] rand_energy();
		case ($urandom_range(0, 7))
			0:       return $urandom;
			1, 2:    return $signed(24'($urandom_range(0, 1 << 19))) - (1 << 18);
			default: return $signed(24'($urandom_range(0, 1 << 15))) - (1 << 14);
		endcase
	endfunction

	function automatic logic [4:0] rand_class();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 21);
			1:       return FIXED_CLASS;
			2, 3:    return 5'd5;
			default: return 5'd10;
		endcase
	endfunction

	function automatic sam_req_t rand_req();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return mk_table($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
				rand_energy());
		if (pick < 20)
			return mk_pos($urandom_range(0, 63), peak_set[$urandom_range(0, N_PEAKS - 1)],
				rand_class());
		if (pick < 27)
			return noise_req();
		if (pick < 92)
			return mk_swap($urandom_range(0, cfg_len - 1), $urandom_range(0, cfg_len - 1),
				$urandom_range(0, 65535));
		return mk_swap($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
	endfunction

	// ---- sender ----------------------------------------------------------------
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_req(input sam_req_t r);
		@(negedge clk);
		in_valid = 1'b1;
		in_data  = r;
		do @(posedge clk); while (!in_ready);
		results_pending.push_back(anneal_predict(r));
		n_sent++;
		// bursts of random length; some long ones with no gap at all
		burst_left--;
		if (burst_left <= 0) begin
			pause_sender($urandom_range(1, 8));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
		end
	endtask

	task automatic wait_results_drained();
		pause_sender(0);
		while (results_pending.size() != 0)
			@(negedge clk);
		// every request yields a result, so the block is idle here
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_USED_LENGTH: cfg_len  = (val[6:0] > 64) ? 64 : val[6:0];
			REG_MAP_COUNT:   cfg_maps = (val[1:0] > 2) ? 2 : val[1:0];
			REG_WEIGHT0:     cfg_w[0] = val[15:0];
			REG_WEIGHT1:     cfg_w[1] = val[15:0];
			REG_INV_TEMP:    cfg_invt = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_settings(input int len, maps, input logic [15:0] w0, w1,
			input logic [31:0] invt);
		wait_results_drained();
		write_reg(REG_USED_LENGTH, len);
		write_reg(REG_MAP_COUNT, maps);
		write_reg(REG_WEIGHT0, w0);
		write_reg(REG_WEIGHT1, w1);
		write_reg(REG_INV_TEMP, invt);
	endtask

	// ---- receiver --------------------------------------------------------------
	// own stall pattern: phases of always-ready, coin-flip and mostly-stalled,
	// overridden by a long hold-off when a test asks for one
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			if (rx_phase_left <= 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_phase_left = $urandom_range(20, 120);
			end
			rx_phase_left--;
			case (rx_mode)
				0:       out_ready = 1'b1;
				1:       out_ready = $urandom_range(0, 1);
				default: out_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---- result checker --------------------------------------------------------
	sam_res_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_pending.size() == 0) begin
				orphans++;
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with no request pending: status=%0d", out_data.status);
			end else begin
				want = results_pending.pop_front();
				n_checked++;
				if (want.status <= ST_INVALID)
					status_seen[want.status]++;
				if (out_data.status !== want.status ||
						out_data.total_energy !== want.total_energy ||
						out_data.map0_energy !== want.map0_energy ||
						out_data.map1_energy !== want.map1_energy ||
						out_data.delta_energy !== want.delta_energy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result %0d: status %0d/%0d total %0d/%0d map0 %0d/%0d map1 %0d/%0d delta %0d/%0d (exp/got)",
							n_checked, want.status, out_data.status,
							want.total_energy, out_data.total_energy,
							want.map0_energy, out_data.map0_energy,
							want.map1_energy, out_data.map1_energy,
							want.delta_energy, out_data.delta_energy);
				end
			end
		end
	end

	// ---- watchdog --------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycle_count, results_pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---- tests -----------------------------------------------------------------
	// load every table entry between chain peaks and place a peak on every slot
	task automatic test_fill_stores();
		for (int m = 0; m < 2; m++)
			for (int i = 0; i < N_PEAKS; i++)
				for (int j = 0; j < N_PEAKS; j++)
					send_req(mk_table(m, peak_set[i], peak_set[j], rand_energy()));
		for (int p = 0; p < 64; p++)
			send_req(mk_pos(p, peak_set[$urandom_range(0, N_PEAKS - 1)], rand_class()));
	endtask

	task automatic test_directed();
		sam_req_t r;
		apply_settings(64, 2, 16'd4096, 16'd4096, 32'h0100_0000);
		// energy extremes on the 63/0 corners
		send_req(mk_table(0, 63, 63, -24'sd8388608));
		send_req(mk_table(1, 0, 0, 24'sd8388607));
		send_req(mk_table(1, 63, 0, 24'sd1000));
		send_req(mk_pos(0, 63, 5'd5));
		send_req(mk_pos(1, 0, 5'd5));
		send_req(mk_pos(2, 63, 5'd5));
		send_req(mk_pos(3, 1, FIXED_CLASS));
		send_req(mk_pos(4, 2, FIXED_CLASS));
		send_req(mk_pos(5, 4, 5'd7));
		send_req(mk_pos(63, 32, 5'd5));
		r = noise_req();
		send_req(r);
		// same peak on both slots: zero delta, tie decided at exactly one half
		send_req(mk_swap(0, 2, HALF_Q16));
		send_req(mk_swap(2, 0, HALF_Q16 + 16'd1));
		// fixed class, class mismatch, same slot
		send_req(mk_swap(3, 4, 16'd0));
		send_req(mk_swap(0, 5, 16'd0));
		send_req(mk_swap(1, 1, 16'd0));
		// neighbors, chain ends, reversed order, random extremes
		send_req(mk_swap(0, 1, 16'd0));
		send_req(mk_swap(1, 63, 16'd65535));
		send_req(mk_swap(63, 0, 16'd0));
		send_req(mk_swap(2, 63, 16'd65535));
		// three-slot chain: out-of-range slot, the only two links
		apply_settings(3, 2, 16'd4096, 16'd4096, 32'h0100_0000);
		send_req(noise_req());
		send_req(mk_swap(0, 5, 16'd100));
		send_req(mk_swap(2, 0, 16'd100));
		send_req(mk_swap(1, 2, 16'd40000));
	endtask

	task automatic test_random_phase(input int count);
		send_req(noise_req());
		repeat (count) send_req(rand_req());
	endtask

	// receiver stalls long while requests keep coming, so input backs up
	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 400;
		repeat (20) send_req(rand_req());
		wait_results_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_USED_LENGTH;
		cfg_wdata = '0;
		mismatches = 0;
		orphans = 0;
		n_checked = 0;
		n_sent = 0;
		status_seen = '{default: 0};
		cycle_count = 0;
		burst_left = 1;
		hold_left = 0;
		rx_mode = 0;
		rx_phase_left = 0;
		held_map = '{0, 0};
		held_total = 0;
		cfg_len = 64;
		cfg_maps = 2;
		cfg_w = '{4096, 4096};
		cfg_invt = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_stores();
		test_directed();

		apply_settings(64, 2, 16'd4096, 16'd4096, 32'h0100_0000);
		test_random_phase(220);
		test_backpressure();
		apply_settings(3, 1, 16'd65535, 16'd4096, 32'h0000_0000);
		test_random_phase(160);
		apply_settings(17, 2, 16'd0, 16'd65535, 32'hFFFF_FFFF);
		test_random_phase(200);
		apply_settings(40, 2, 16'd2000, 16'd3000, 32'h0040_0000);
		test_random_phase(200);
		apply_settings(64, 1, 16'd4096, 16'd0, 32'h0400_0000);
		test_random_phase(200);

		wait_results_drained();
		repeat (600) @(posedge clk);
		if (results_pending.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d results never arrived", results_pending.size());
		end
		$display("Covered %0d requests over six register settings: %0d loads/recomputes, %0d drops,",
			n_sent, status_seen[ST_LOAD_DONE], status_seen[ST_DROP]);
		$display("  %0d ties/rises, %0d rejects, %0d invalid swaps; %0d mismatches",
			status_seen[ST_RISE], status_seen[ST_REJECT], status_seen[ST_INVALID], mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
